@@ design/afts_pkg.sv @@
`default_nettype none
package afts_pkg;

    // CORDIC iteration count, capped by the length of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    // angle constants, degrees with 8 fraction bits
    localparam int FULL_TURN     = 92160;
    localparam int HALF_TURN     = 46080;
    localparam int QUARTER_TURN  = 23040;
    localparam int THREE_QUARTER = 69120;

    // CORDIC start value K, 30 fraction bits
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    typedef struct packed {
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic signed [23:0] position_x;
        logic signed [23:0] position_y;
        logic        [16:0] reduced_rotation;
        logic               flip;
    } item_t;

    // arctangent of 2^-i in degrees, 24 fraction bits
    function automatic logic signed [32:0] atan_q24(input logic [4:0] idx);
        logic signed [32:0] v;
        unique case (idx)
            5'd0:    v = 33'sd754974720;
            5'd1:    v = 33'sd445687602;
            5'd2:    v = 33'sd235489089;
            5'd3:    v = 33'sd119537938;
            5'd4:    v = 33'sd60000934;
            5'd5:    v = 33'sd30029717;
            5'd6:    v = 33'sd15018523;
            5'd7:    v = 33'sd7509720;
            5'd8:    v = 33'sd3754917;
            5'd9:    v = 33'sd1877466;
            5'd10:   v = 33'sd938734;
            5'd11:   v = 33'sd469367;
            5'd12:   v = 33'sd234684;
            5'd13:   v = 33'sd117342;
            5'd14:   v = 33'sd58671;
            5'd15:   v = 33'sd29335;
            5'd16:   v = 33'sd14668;
            5'd17:   v = 33'sd7334;
            5'd18:   v = 33'sd3667;
            5'd19:   v = 33'sd1833;
            5'd20:   v = 33'sd917;
            5'd21:   v = 33'sd458;
            5'd22:   v = 33'sd229;
            5'd23:   v = 33'sd115;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ design/afts_angle.sv @@
`default_nettype none
module afts_angle
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  wire                      in_valid,
    input  wire  signed [23:0]       rotation_deg,
    input  wire  afts_pkg::item_t    in_side,
    output logic                     out_valid,
    output logic signed [32:0]       out_z,
    output afts_pkg::item_t          out_side
);

    // floor(2^40 / 92160, one full turn of 360 degrees); estimate is exact or one low
    localparam logic [48:0] RECIP = 49'd11930464;
    // multiple of a full turn that makes any rotation positive
    localparam logic signed [24:0] BIAS = 25'sd8478720;

    logic              v1_reg, v2_reg, v3_reg;
    logic [24:0]       u_reg;
    logic [8:0]        q_reg;
    logic [16:0]       a_reg;
    logic signed [32:0] z_reg;
    afts_pkg::item_t   s1_reg, s2_reg, s3_reg;

    logic [24:0]       u_next;
    logic [48:0]       prod;
    logic [24:0]       r_full;
    logic [17:0]       r_w;
    logic [16:0]       a_next;
    logic signed [17:0] z_deg;
    logic              flip_next;
    afts_pkg::item_t   s2_next;
    afts_pkg::item_t   s3_next;

    always_comb
    begin
        u_next = 25'($signed({rotation_deg[23], rotation_deg}) + BIAS);
        prod   = {24'd0, u_next} * RECIP;
        r_full = u_reg - (25'(q_reg) * 25'(afts_pkg::FULL_TURN));
        r_w    = r_full[17:0];
        if (r_w >= 18'(afts_pkg::FULL_TURN))
            a_next = 17'(r_w - 18'(afts_pkg::FULL_TURN));
        else
            a_next = r_w[16:0];
        s2_next                  = s1_reg;
        s2_next.reduced_rotation = a_next;
        // fold into [-90,90] degrees
        flip_next = 1'b0;
        if (a_reg <= 17'(afts_pkg::QUARTER_TURN))
            z_deg = $signed({1'b0, a_reg});
        else if (a_reg < 17'(afts_pkg::THREE_QUARTER))
        begin
            z_deg = $signed({1'b0, a_reg}) - 18'sd46080;
            flip_next = 1'b1;
        end
        else
            z_deg = $signed({1'b0, a_reg}) - 18'sd92160;
        s3_next      = s2_reg;
        s3_next.flip = flip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg  <= u_next;
            q_reg  <= prod[48:40];
            s1_reg <= in_side;
            a_reg  <= a_next;
            s2_reg <= s2_next;
            z_reg  <= 33'(z_deg) <<< 16;
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_z     = z_reg;
    assign out_side  = s3_reg;

endmodule
`default_nettype wire

@@ design/afts_cordic.sv @@
`default_nettype none
module afts_cordic
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  wire                      in_valid,
    input  wire  signed [32:0]       in_z,
    input  wire  afts_pkg::item_t    in_side,
    output logic                     out_valid,
    output logic signed [31:0]       out_x,
    output logic signed [31:0]       out_y,
    output afts_pkg::item_t          out_side
);

    localparam int N = afts_pkg::CORDIC_ITERS;

    logic                v_reg [N];
    logic signed [31:0]  x_reg [N];
    logic signed [31:0]  y_reg [N];
    logic signed [32:0]  z_reg [N];
    afts_pkg::item_t     s_reg [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            logic                xi;
            logic signed [31:0]  x_in, y_in;
            logic signed [32:0]  z_in;
            logic                v_in;
            afts_pkg::item_t     s_in;

            if (i == 0)
            begin : g_first
                assign x_in = afts_pkg::CORDIC_GAIN;
                assign y_in = 32'sd0;
                assign z_in = in_z;
                assign v_in = in_valid;
                assign s_in = in_side;
            end
            else
            begin : g_next
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
                assign v_in = v_reg[i-1];
                assign s_in = s_reg[i-1];
            end

            assign xi = ~z_in[32];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= v_in;
            end

            // rotate toward zero residual angle
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (xi)
                    begin
                        x_reg[i] <= x_in - (y_in >>> i);
                        y_reg[i] <= y_in + (x_in >>> i);
                        z_reg[i] <= z_in - afts_pkg::atan_q24(5'(i));
                    end
                    else
                    begin
                        x_reg[i] <= x_in + (y_in >>> i);
                        y_reg[i] <= y_in - (x_in >>> i);
                        z_reg[i] <= z_in + afts_pkg::atan_q24(5'(i));
                    end
                    s_reg[i] <= s_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N-1];
    assign out_x     = x_reg[N-1];
    assign out_y     = y_reg[N-1];
    assign out_side  = s_reg[N-1];

endmodule
`default_nettype wire

@@ design/afts_matrix.sv @@
`default_nettype none
module afts_matrix
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  wire                      in_valid,
    input  wire  signed [31:0]       in_x,
    input  wire  signed [31:0]       in_y,
    input  wire  afts_pkg::item_t    in_side,
    output logic                     out_valid,
    output logic signed [23:0]       m00,
    output logic signed [23:0]       m01,
    output logic signed [31:0]       m02,
    output logic signed [23:0]       m10,
    output logic signed [23:0]       m11,
    output logic signed [31:0]       m12,
    output logic        [16:0]       reduced_rotation,
    output logic                     saturated
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [25:0] sxc_reg, sys_reg, sxs_reg, syc_reg;
    logic signed [25:0] sxc2_reg, sys2_reg, sxs2_reg, syc2_reg;
    logic signed [33:0] oxc_reg, oys_reg, oxs_reg, oyc_reg;
    afts_pkg::item_t    s1_reg, s2_reg;

    logic signed [23:0] m00_reg, m01_reg, m10_reg, m11_reg;
    logic signed [31:0] m02_reg, m12_reg;
    logic [16:0]        rr_reg;
    logic               sat_reg;

    logic signed [31:0] c, s;
    logic signed [55:0] p_sxc, p_sys, p_sxs, p_syc;
    logic signed [49:0] p_oxc, p_oys, p_oxs, p_oyc;
    logic signed [25:0] nsxs;
    logic signed [35:0] tx, ty;
    logic               sat_next;

    function automatic logic signed [23:0] clip24(input logic signed [25:0] v);
        if (v > 26'sd8388607)
            return 24'sh7fffff;
        else if (v < -26'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic out24(input logic signed [25:0] v);
        return (v > 26'sd8388607) || (v < -26'sd8388608);
    endfunction

    function automatic logic out32(input logic signed [35:0] v);
        return (v > 36'sd2147483647) || (v < -36'sd2147483648);
    endfunction

    always_comb
    begin
        // undo the half-turn fold; sine of the negated angle
        c = in_side.flip ? -in_x : in_x;
        s = in_side.flip ? in_y : -in_y;
        p_sxc = 56'(in_side.scale_x) * 56'(c) + 56'sd536870912;
        p_sys = 56'(in_side.scale_y) * 56'(s) + 56'sd536870912;
        p_sxs = 56'(in_side.scale_x) * 56'(s) + 56'sd536870912;
        p_syc = 56'(in_side.scale_y) * 56'(c) + 56'sd536870912;

        p_oxc = 50'(s1_reg.origin_x) * 50'(sxc_reg) + 50'sd32768;
        p_oys = 50'(s1_reg.origin_y) * 50'(sys_reg) + 50'sd32768;
        p_oxs = 50'(s1_reg.origin_x) * 50'(sxs_reg) + 50'sd32768;
        p_oyc = 50'(s1_reg.origin_y) * 50'(syc_reg) + 50'sd32768;

        nsxs = -sxs2_reg;
        tx = -36'(oxc_reg) - 36'(oys_reg) + 36'(s2_reg.position_x);
        ty = 36'(oxs_reg) - 36'(oyc_reg) + 36'(s2_reg.position_y);
        sat_next = out24(sxc2_reg) | out24(sys2_reg) | out24(nsxs) | out24(syc2_reg)
                 | out32(tx) | out32(ty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxc_reg  <= 26'(p_sxc >>> 30);
            sys_reg  <= 26'(p_sys >>> 30);
            sxs_reg  <= 26'(p_sxs >>> 30);
            syc_reg  <= 26'(p_syc >>> 30);
            s1_reg   <= in_side;

            oxc_reg  <= 34'(p_oxc >>> 16);
            oys_reg  <= 34'(p_oys >>> 16);
            oxs_reg  <= 34'(p_oxs >>> 16);
            oyc_reg  <= 34'(p_oyc >>> 16);
            sxc2_reg <= sxc_reg;
            sys2_reg <= sys_reg;
            sxs2_reg <= sxs_reg;
            syc2_reg <= syc_reg;
            s2_reg   <= s1_reg;

            m00_reg  <= clip24(sxc2_reg);
            m01_reg  <= clip24(sys2_reg);
            m10_reg  <= clip24(nsxs);
            m11_reg  <= clip24(syc2_reg);
            m02_reg  <= clip32(tx);
            m12_reg  <= clip32(ty);
            rr_reg   <= s2_reg.reduced_rotation;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid        = v3_reg;
    assign m00              = m00_reg;
    assign m01              = m01_reg;
    assign m02              = m02_reg;
    assign m10              = m10_reg;
    assign m11              = m11_reg;
    assign m12              = m12_reg;
    assign reduced_rotation = rr_reg;
    assign saturated        = sat_reg;

endmodule
`default_nettype wire

@@ design/affine_2d_transform_setup.sv @@
// Pipeline: 3 angle-reduction stages + CORDIC_ITERS CORDIC stages (16) + 3 product
//   stages lie between an accepted input beat and its output beat.
// Throughput: one beat per cycle; the whole pipeline advances together, held only
//   while an output beat waits on m_tready.
// Reset: rst_n is asynchronous, active low, and clears every stage valid bit; the
//   data path registers are not reset.
`default_nettype none
module affine_2d_transform_setup
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           s_tvalid,
    output logic          s_tready,
    // rotation_deg, scale_x, scale_y, origin_x, origin_y, position_x, position_y
    input  wire  [167:0]  s_tdata,
    output logic          m_tvalid,
    input  wire           m_tready,
    // m00, m01, m02, m10, m11, m12, reduced_rotation, 7 zero pad bits
    output logic [183:0]  m_tdata,
    // saturated
    output logic          m_tuser
);

    logic               en;
    afts_pkg::item_t    in_side;

    logic               ang_valid;
    logic signed [32:0] ang_z;
    afts_pkg::item_t    ang_side;

    logic               cor_valid;
    logic signed [31:0] cor_x, cor_y;
    afts_pkg::item_t    cor_side;

    logic signed [23:0] m00, m01, m10, m11;
    logic signed [31:0] m02, m12;
    logic [16:0]        reduced_rotation;
    logic               saturated;

    // advance the pipeline unless a finished beat is held at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb
    begin
        in_side.scale_x          = s_tdata[47:24];
        in_side.scale_y          = s_tdata[71:48];
        in_side.origin_x         = s_tdata[95:72];
        in_side.origin_y         = s_tdata[119:96];
        in_side.position_x       = s_tdata[143:120];
        in_side.position_y       = s_tdata[167:144];
        in_side.reduced_rotation = 17'd0;
        in_side.flip             = 1'b0;
    end

    // reduce the rotation into a full turn, fold to [-90,90] degrees
    afts_angle u_angle
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_tvalid),
        .rotation_deg (s_tdata[23:0]),
        .in_side      (in_side),
        .out_valid    (ang_valid),
        .out_z        (ang_z),
        .out_side     (ang_side)
    );

    // one rotation step per stage
    afts_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ang_valid),
        .in_z      (ang_z),
        .in_side   (ang_side),
        .out_valid (cor_valid),
        .out_x     (cor_x),
        .out_y     (cor_y),
        .out_side  (cor_side)
    );

    // scale products, pivot terms, saturation; last stage is the output register
    afts_matrix u_matrix
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (cor_valid),
        .in_x             (cor_x),
        .in_y             (cor_y),
        .in_side          (cor_side),
        .out_valid        (m_tvalid),
        .m00              (m00),
        .m01              (m01),
        .m02              (m02),
        .m10              (m10),
        .m11              (m11),
        .m12              (m12),
        .reduced_rotation (reduced_rotation),
        .saturated        (saturated)
    );

    assign m_tdata = {7'd0, reduced_rotation, m12, m11, m10, m02, m01, m00};
    assign m_tuser = saturated;

    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (reduced_rotation < 17'd92160))
        else $error("reduced rotation out of range");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && saturated) |->
            (m00 == 24'sh7fffff || m00 == 24'sh800000 || m01 == 24'sh7fffff ||
             m01 == 24'sh800000 || m10 == 24'sh7fffff || m10 == 24'sh800000 ||
             m11 == 24'sh7fffff || m11 == 24'sh800000 || m02 == 32'sh7fffffff ||
             m02 == 32'sh80000000 || m12 == 32'sh7fffffff || m12 == 32'sh80000000))
        else $error("saturation flag without a clipped coefficient");

    a_adv_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(en))
        else $error("output beat appeared while the pipeline was held");

endmodule
`default_nettype wire
